// ===== rtl/lrts_pkg.sv =====
// ----------------------------------------------------------------------------
// lrts_pkg
// Types, codes and reset values shared by the link retry/timeout sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrts_pkg;

   localparam int unsigned CounterWidth = 18;
   localparam int unsigned TimeWidth    = 16;
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [TimeWidth-1:0] ReconnectDelayReset = 16'd1000;
   localparam logic [TimeWidth-1:0] ConnectTimeoutReset = 16'd1000;
   localparam logic [TimeWidth-1:0] ReplyTimeoutReset   = 16'd3000;
   localparam logic [TimeWidth-1:0] PollPeriodReset     = 16'd200;

   typedef enum logic [3:0] {
      PH_IDLE            = 4'd0,
      PH_WAIT_RECONNECT  = 4'd1,
      PH_CONNECT         = 4'd2,
      PH_WAIT_CONNECTION = 4'd3,
      PH_SEND_CONTROL    = 4'd4,
      PH_WAIT_STATUS     = 4'd5,
      PH_WAIT_PERIOD     = 4'd6,
      PH_SEND_PROGRAM    = 4'd7,
      PH_WAIT_PROGRAM    = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_OPEN    = 3'd1,
      ACT_DROP    = 3'd2,
      ACT_PROGRAM = 3'd3,
      ACT_POLL    = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      MODE_TICK         = 3'd0,
      MODE_LINK_REQUEST = 3'd1,
      MODE_PROGRAM      = 3'd2,
      MODE_STATUS_REPLY = 3'd3,
      MODE_ANSWER       = 3'd4,
      MODE_DISCONNECTED = 3'd5
   } mode_type;

   localparam logic [1:0] SOCK_UNCONNECTED = 2'd0;
   localparam logic [1:0] SOCK_CONNECTED   = 2'd2;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_ADDRESS_VALID   = 5'h00,
      CSR_RECONNECT_DELAY = 5'h04,
      CSR_CONNECT_TIMEOUT = 5'h08,
      CSR_REPLY_TIMEOUT   = 5'h0C,
      CSR_POLL_PERIOD     = 5'h10
   } csr_addr_type;

   typedef struct packed {
      logic [2:0]           mode;
      logic [TimeWidth-1:0] tick_amount;
      logic [1:0]           socket_state;
      logic                 run_on_load;
      logic                 flash_request;
      logic                 answer_for_program;
   } req_word_type;

endpackage

`default_nettype wire

// ===== rtl/lrts_req_if.sv =====
// ----------------------------------------------------------------------------
// lrts_req_if
// Event channel into the sequencer: valid/ready plus the event word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [15:0] tick_amount;
   logic [1:0]  socket_state;
   logic        run_on_load;
   logic        flash_request;
   logic        answer_for_program;

   modport source (
      output valid, mode, tick_amount, socket_state, run_on_load, flash_request,
             answer_for_program,
      input  ready
   );
   modport sink (
      input  valid, mode, tick_amount, socket_state, run_on_load, flash_request,
             answer_for_program,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/lrts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lrts_rsp_if
// Result channel out of the sequencer: valid/ready plus the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrts_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic       run_flag_out;
   logic [3:0] phase_out;

   modport source (
      output valid, action, run_flag_out, phase_out,
      input  ready
   );
   modport sink (
      input  valid, action, run_flag_out, phase_out,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/link_retry_timeout_sequencer.sv =====
// ----------------------------------------------------------------------------
// link_retry_timeout_sequencer
// Supervisor for a request/response link: connect, retry, program, poll.
// ----------------------------------------------------------------------------
// One event word is taken per clock while the result side takes words, and
// each gives exactly one result word. The event is captured in an input
// register; the phase logic (one 19-bit subtract with saturation and a phase
// decode) then lands in the result register together with the updated
// supervisor state. The input register takes a new word as its word moves
// on, so throughput is one word per cycle whenever the result side takes words.
// Registers sit on the APB port at byte addresses 0x00..0x10 and are meant
// to be written only while no event is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module link_retry_timeout_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   lrts_req_if.sink                               req,
   lrts_rsp_if.source                             rsp,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [lrts_pkg::CsrAddrWidth-1:0] paddr,
   input  wire logic [lrts_pkg::CsrDataWidth-1:0] pwdata,
   output logic      [lrts_pkg::CsrDataWidth-1:0] prdata,
   output logic                                   pready
);

   localparam int unsigned CW = lrts_pkg::CounterWidth;
   localparam int unsigned TW = lrts_pkg::TimeWidth;

   // ---------------- configuration registers ----------------
   logic          address_valid_ff;
   logic [TW-1:0] reconnect_delay_ff;
   logic [TW-1:0] connect_timeout_ff;
   logic [TW-1:0] reply_timeout_ff;
   logic [TW-1:0] poll_period_ff;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         address_valid_ff   <= 1'b0;
         reconnect_delay_ff <= lrts_pkg::ReconnectDelayReset;
         connect_timeout_ff <= lrts_pkg::ConnectTimeoutReset;
         reply_timeout_ff   <= lrts_pkg::ReplyTimeoutReset;
         poll_period_ff     <= lrts_pkg::PollPeriodReset;
      end else if (csr_write) begin
         case (paddr)
            lrts_pkg::CSR_ADDRESS_VALID:   address_valid_ff   <= pwdata[0];
            lrts_pkg::CSR_RECONNECT_DELAY: reconnect_delay_ff <= pwdata[TW-1:0];
            lrts_pkg::CSR_CONNECT_TIMEOUT: connect_timeout_ff <= pwdata[TW-1:0];
            lrts_pkg::CSR_REPLY_TIMEOUT:   reply_timeout_ff   <= pwdata[TW-1:0];
            lrts_pkg::CSR_POLL_PERIOD:     poll_period_ff     <= pwdata[TW-1:0];
            default: ;
         endcase
      end
   end

   // Read-back mux; unmapped addresses read zero.
   always_comb begin
      prdata = '0;
      case (paddr)
         lrts_pkg::CSR_ADDRESS_VALID:   prdata[0]      = address_valid_ff;
         lrts_pkg::CSR_RECONNECT_DELAY: prdata[TW-1:0] = reconnect_delay_ff;
         lrts_pkg::CSR_CONNECT_TIMEOUT: prdata[TW-1:0] = connect_timeout_ff;
         lrts_pkg::CSR_REPLY_TIMEOUT:   prdata[TW-1:0] = reply_timeout_ff;
         lrts_pkg::CSR_POLL_PERIOD:     prdata[TW-1:0] = poll_period_ff;
         default:                       prdata         = '0;
      endcase
   end

   // ---------------- pipeline handshake ----------------
   logic                   in_valid_ff;
   lrts_pkg::req_word_type in_word_ff;
   logic                   out_valid_ff;
   logic                   advance;      // input word moves to result register

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_word_ff.mode               <= req.mode;
         in_word_ff.tick_amount        <= req.tick_amount;
         in_word_ff.socket_state       <= req.socket_state;
         in_word_ff.run_on_load        <= req.run_on_load;
         in_word_ff.flash_request      <= req.flash_request;
         in_word_ff.answer_for_program <= req.answer_for_program;
      end
   end

   // ---------------- supervisor state ----------------
   lrts_pkg::phase_type phase_ff, phase_in;
   logic signed [CW-1:0] counter_ff, counter_in;
   logic                 pending_ff, pending_in;
   logic                 run_flag_ff, run_flag_in;

   // Countdown: by one while waiting for the connection, else by the tick amount.
   logic [TW-1:0]        dec_amount;
   logic signed [CW:0]   diff;
   logic signed [CW-1:0] counter_sub;
   logic                 expired;

   assign dec_amount = (in_word_ff.mode == lrts_pkg::MODE_TICK &&
                        phase_ff == lrts_pkg::PH_WAIT_CONNECTION)
                       ? TW'(1) : in_word_ff.tick_amount;
   assign diff = {counter_ff[CW-1], counter_ff} - $signed({{(CW+1-TW){1'b0}}, dec_amount});
   // Saturate at the most negative counter value.
   assign counter_sub = (diff[CW] != diff[CW-1]) ? {1'b1, {(CW-1){1'b0}}} : diff[CW-1:0];
   assign expired     = counter_sub[CW-1];

   // Output decode: action for this event.
   lrts_pkg::action_type act;

   always_comb begin
      act = lrts_pkg::ACT_NONE;
      case (in_word_ff.mode)
         lrts_pkg::MODE_TICK: begin
            case (phase_ff)
               lrts_pkg::PH_CONNECT: begin
                  if (address_valid_ff && in_word_ff.socket_state == lrts_pkg::SOCK_UNCONNECTED)
                     act = lrts_pkg::ACT_OPEN;
               end
               lrts_pkg::PH_WAIT_CONNECTION: begin
                  if (in_word_ff.socket_state != lrts_pkg::SOCK_CONNECTED && expired)
                     act = lrts_pkg::ACT_DROP;
               end
               lrts_pkg::PH_SEND_CONTROL: act = lrts_pkg::ACT_POLL;
               lrts_pkg::PH_WAIT_STATUS,
               lrts_pkg::PH_WAIT_PROGRAM: begin
                  if (expired) act = lrts_pkg::ACT_DROP;
               end
               lrts_pkg::PH_SEND_PROGRAM: begin
                  if (pending_ff) act = lrts_pkg::ACT_PROGRAM;
               end
               default: act = lrts_pkg::ACT_NONE;
            endcase
         end
         lrts_pkg::MODE_LINK_REQUEST,
         lrts_pkg::MODE_DISCONNECTED: act = lrts_pkg::ACT_DROP;
         default: act = lrts_pkg::ACT_NONE;
      endcase
   end

   // Next-state decode.
   always_comb begin
      phase_in    = phase_ff;
      counter_in  = counter_ff;
      pending_in  = pending_ff;
      run_flag_in = run_flag_ff;
      if (act == lrts_pkg::ACT_DROP) begin
         // Reconnect: drop, then wait before the next attempt.
         counter_in = $signed({{(CW-TW){1'b0}}, reconnect_delay_ff});
         phase_in   = lrts_pkg::PH_WAIT_RECONNECT;
      end else begin
         case (in_word_ff.mode)
            lrts_pkg::MODE_TICK: begin
               case (phase_ff)
                  lrts_pkg::PH_WAIT_RECONNECT: begin
                     counter_in = counter_sub;
                     if (expired) phase_in = lrts_pkg::PH_CONNECT;
                  end
                  lrts_pkg::PH_CONNECT: begin
                     if (!address_valid_ff) begin
                        phase_in = lrts_pkg::PH_IDLE;
                     end else if (act == lrts_pkg::ACT_OPEN) begin
                        counter_in = $signed({{(CW-TW){1'b0}}, connect_timeout_ff});
                        phase_in   = lrts_pkg::PH_WAIT_CONNECTION;
                     end
                  end
                  lrts_pkg::PH_WAIT_CONNECTION: begin
                     if (in_word_ff.socket_state == lrts_pkg::SOCK_CONNECTED)
                        phase_in = lrts_pkg::PH_SEND_PROGRAM;
                     else
                        counter_in = counter_sub;
                  end
                  lrts_pkg::PH_SEND_CONTROL: begin
                     counter_in = $signed({{(CW-TW){1'b0}}, reply_timeout_ff});
                     phase_in   = lrts_pkg::PH_WAIT_STATUS;
                  end
                  lrts_pkg::PH_WAIT_STATUS,
                  lrts_pkg::PH_WAIT_PROGRAM: counter_in = counter_sub;
                  lrts_pkg::PH_WAIT_PERIOD: begin
                     counter_in = counter_sub;
                     if (expired) phase_in = lrts_pkg::PH_SEND_CONTROL;
                  end
                  lrts_pkg::PH_SEND_PROGRAM: begin
                     if (pending_ff) begin
                        counter_in = $signed({{(CW-TW){1'b0}}, reply_timeout_ff});
                        phase_in   = lrts_pkg::PH_WAIT_PROGRAM;
                     end else begin
                        phase_in = lrts_pkg::PH_SEND_CONTROL;
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
            lrts_pkg::MODE_PROGRAM: begin
               run_flag_in = in_word_ff.run_on_load;
               pending_in  = in_word_ff.flash_request;
            end
            lrts_pkg::MODE_STATUS_REPLY: phase_in = lrts_pkg::PH_SEND_PROGRAM;
            lrts_pkg::MODE_ANSWER: begin
               if (in_word_ff.answer_for_program) begin
                  counter_in = $signed({{(CW-TW){1'b0}}, poll_period_ff});
                  phase_in   = lrts_pkg::PH_WAIT_PERIOD;
                  pending_in = 1'b0;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= lrts_pkg::PH_IDLE;
         counter_ff  <= '0;
         pending_ff  <= 1'b0;
         run_flag_ff <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         counter_ff  <= counter_in;
         pending_ff  <= pending_in;
         run_flag_ff <= run_flag_in;
      end
   end

   // ---------------- result register ----------------
   logic [2:0] action_ff;
   logic       run_out_ff;
   logic [3:0] phase_out_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         action_ff    <= act;
         run_out_ff   <= (act == lrts_pkg::ACT_PROGRAM) ? run_flag_ff : 1'b0;
         phase_out_ff <= phase_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.action       = action_ff;
   assign rsp.run_flag_out = run_out_ff;
   assign rsp.phase_out    = phase_out_ff;

`ifndef SYNTHESIS
   a_drop_to_retry: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.action == lrts_pkg::ACT_DROP |->
         rsp.phase_out == lrts_pkg::PH_WAIT_RECONNECT)
      else $error("drop without retry wait");
   a_open_to_wait: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.action == lrts_pkg::ACT_OPEN |->
         rsp.phase_out == lrts_pkg::PH_WAIT_CONNECTION)
      else $error("open without connection wait");
   a_poll_to_wait: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.action == lrts_pkg::ACT_POLL |->
         rsp.phase_out == lrts_pkg::PH_WAIT_STATUS)
      else $error("poll without status wait");
   a_program_to_wait: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.action == lrts_pkg::ACT_PROGRAM |->
         rsp.phase_out == lrts_pkg::PH_WAIT_PROGRAM && !pending_ff == 1'b0)
      else $error("program send without ack wait");
   a_run_only_with_program: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.run_flag_out |-> rsp.action == lrts_pkg::ACT_PROGRAM)
      else $error("run flag outside program send");
   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(counter_ff))
      else $error("state moved without an event");
`endif

endmodule

`default_nettype wire
